@@ rtl/msfp_pkg.sv @@
`timescale 1ns / 1ps

package msfp_pkg;

	// Frame geometry
	localparam int PAYLOAD_BYTES = 12;
	localparam int SPEED_COUNT   = 6;
	localparam int SPEED_BYTES   = 2 * SPEED_COUNT;
	localparam int STORE_DEPTH   = (PAYLOAD_BYTES < SPEED_BYTES) ? PAYLOAD_BYTES : SPEED_BYTES;
	localparam int STORE_IDX_W   = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int CNT_W         = $clog2(PAYLOAD_BYTES + 1);
	localparam logic [CNT_W-1:0] LAST_PAYLOAD = CNT_W'(PAYLOAD_BYTES - 1);

	// Frame queue
	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	// Configuration
	localparam int CFG_IDX_W = 1;
	localparam logic [7:0] SYNC_FIRST_RST  = 8'd170;
	localparam logic [7:0] SYNC_SECOND_RST = 8'd85;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SYNC_FIRST  = 1'b0,
		REG_SYNC_SECOND = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		PH_HUNT    = 2'd0,
		PH_SYNC2   = 2'd1,
		PH_PAYLOAD = 2'd2,
		PH_CHECK   = 2'd3
	} phase_t;

	typedef logic [SPEED_COUNT-1:0][15:0] frame_t;

	typedef struct packed {
		logic   valid;
		frame_t frame;
	} push_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

endpackage

@@ rtl/msfp_front.sv @@
`timescale 1ns / 1ps

module msfp_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            rx_valid,
	input  logic [7:0]                      rx_byte,
	output logic                            rx_stall,
	input  logic                            cfg_we,
	input  logic [msfp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                      cfg_data,
	input  msfp_pkg::fifo_stat_t            fifo_stat,
	output msfp_pkg::push_t                 push
);

	msfp_pkg::phase_t              phase_q, phase_nxt;
	logic [msfp_pkg::CNT_W-1:0]    cnt_q, cnt_nxt;
	logic [7:0]                    sum_q, sum_nxt;
	logic [7:0]                    sync_first_q, sync_second_q;
	logic [7:0]                    store_q [msfp_pkg::STORE_DEPTH];
	logic [7:0]                    pay_w [msfp_pkg::SPEED_BYTES];
	logic                          store_we;
	logic                          accept;
	msfp_pkg::frame_t              frame_w;

	// Hold input while the queue cannot take another frame
	assign rx_stall = fifo_stat.full;
	assign accept   = rx_valid && !fifo_stat.full;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_first_q  <= msfp_pkg::SYNC_FIRST_RST;
			sync_second_q <= msfp_pkg::SYNC_SECOND_RST;
		end else if (cfg_we) begin
			case (msfp_pkg::cfg_reg_t'(cfg_index))
				msfp_pkg::REG_SYNC_FIRST:  sync_first_q  <= cfg_data;
				msfp_pkg::REG_SYNC_SECOND: sync_second_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Next parse phase
	always_comb begin
		phase_nxt = phase_q;
		if (accept) begin
			case (phase_q)
				msfp_pkg::PH_HUNT:
					if (rx_byte == sync_first_q) phase_nxt = msfp_pkg::PH_SYNC2;
				msfp_pkg::PH_SYNC2:
					phase_nxt = (rx_byte == sync_second_q) ? msfp_pkg::PH_PAYLOAD
					                                       : msfp_pkg::PH_HUNT;
				msfp_pkg::PH_PAYLOAD:
					if (cnt_q >= msfp_pkg::LAST_PAYLOAD) phase_nxt = msfp_pkg::PH_CHECK;
				msfp_pkg::PH_CHECK:
					phase_nxt = msfp_pkg::PH_HUNT;
				default:
					phase_nxt = msfp_pkg::PH_HUNT;
			endcase
		end
	end

	// Sum, count, store write and frame push
	always_comb begin
		sum_nxt    = sum_q;
		cnt_nxt    = cnt_q;
		store_we   = 1'b0;
		push.valid = 1'b0;
		push.frame = frame_w;
		if (accept) begin
			case (phase_q)
				msfp_pkg::PH_HUNT:
					if (rx_byte == sync_first_q) sum_nxt = rx_byte;
				msfp_pkg::PH_SYNC2: begin
					cnt_nxt = '0;
					if (rx_byte == sync_second_q) sum_nxt = sum_q + rx_byte;
				end
				msfp_pkg::PH_PAYLOAD: begin
					sum_nxt  = sum_q + rx_byte;
					cnt_nxt  = cnt_q + 1'b1;
					store_we = (cnt_q < msfp_pkg::CNT_W'(msfp_pkg::STORE_DEPTH));
				end
				msfp_pkg::PH_CHECK: begin
					cnt_nxt    = '0;
					push.valid = (sum_q == rx_byte);
				end
				default: cnt_nxt = '0;
			endcase
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= msfp_pkg::PH_HUNT;
			cnt_q   <= '0;
			sum_q   <= '0;
		end else begin
			phase_q <= phase_nxt;
			cnt_q   <= cnt_nxt;
			sum_q   <= sum_nxt;
		end
	end

	// Payload bytes, written at the running count
	always_ff @(posedge clk) begin
		if (store_we) store_q[cnt_q[msfp_pkg::STORE_IDX_W-1:0]] <= rx_byte;
	end

	// Positions past the payload read as zero
	for (genvar p = 0; p < msfp_pkg::SPEED_BYTES; p++) begin : g_pay
		if (p < msfp_pkg::STORE_DEPTH) begin : g_st
			assign pay_w[p] = store_q[p];
		end else begin : g_zero
			assign pay_w[p] = 8'd0;
		end
	end

	// Little-endian speed words
	for (genvar k = 0; k < msfp_pkg::SPEED_COUNT; k++) begin : g_spd
		assign frame_w[k] = {pay_w[2*k+1], pay_w[2*k]};
	end

endmodule

@@ rtl/msfp_fifo.sv @@
`timescale 1ns / 1ps

module msfp_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  msfp_pkg::push_t      push,
	input  logic                 pop,
	output msfp_pkg::frame_t     rd_frame,
	output msfp_pkg::fifo_stat_t stat
);

	msfp_pkg::frame_t                  mem_q [msfp_pkg::FIFO_DEPTH];
	logic [msfp_pkg::FIFO_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [msfp_pkg::FIFO_CNT_W-1:0]   cnt_q;
	logic                              do_push, do_pop;

	assign stat.full  = (cnt_q == msfp_pkg::FIFO_CNT_W'(msfp_pkg::FIFO_DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign do_push    = push.valid && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign rd_frame   = mem_q[rd_ptr_q];

	// Store a pushed frame
	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push.frame;
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == msfp_pkg::FIFO_PTR_W'(msfp_pkg::FIFO_DEPTH - 1))
				            ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == msfp_pkg::FIFO_PTR_W'(msfp_pkg::FIFO_DEPTH - 1))
				            ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

@@ rtl/msfp_back.sv @@
`timescale 1ns / 1ps

module msfp_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  msfp_pkg::fifo_stat_t fifo_stat,
	input  msfp_pkg::frame_t     rd_frame,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_stall,
	output msfp_pkg::frame_t     out_frame
);

	logic             valid_q;
	msfp_pkg::frame_t frame_q;

	// Refill the output register when it is empty or being taken
	assign pop       = !fifo_stat.empty && (!valid_q || !out_stall);
	assign out_valid = valid_q;
	assign out_frame = frame_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || !out_stall) begin
			valid_q <= !fifo_stat.empty;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) frame_q <= rd_frame;
	end

endmodule

@@ rtl/motor_speed_frame_parser.sv @@
`timescale 1ns / 1ps
// A frame goes from its checksum byte through the queue into the output register.
// Throughput: one byte per cycle unless rx_stall; the parse state update is the only loop.
// Input stalls only while two matched frames wait in the queue behind a held output.
// Reset (arst_n low, asynchronous): parser hunts, count and sum clear, queue and output empty,
// sync registers return to 170 and 85; payload bytes are not cleared.
module motor_speed_frame_parser (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            rx_valid,
	output logic                            rx_stall,
	input  logic [7:0]                      rx_byte,
	input  logic                            cfg_we,
	input  logic [msfp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                      cfg_data,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [15:0]                     speed_0,
	output logic [15:0]                     speed_1,
	output logic [15:0]                     speed_2,
	output logic [15:0]                     speed_3,
	output logic [15:0]                     speed_4,
	output logic [15:0]                     speed_5
);

	msfp_pkg::push_t      push;
	msfp_pkg::fifo_stat_t fifo_stat;
	msfp_pkg::frame_t     rd_frame;
	msfp_pkg::frame_t     out_frame;
	logic                 pop;

	msfp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx_valid  (rx_valid),
		.rx_byte   (rx_byte),
		.rx_stall  (rx_stall),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.fifo_stat (fifo_stat),
		.push      (push)
	);

	msfp_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.pop      (pop),
		.rd_frame (rd_frame),
		.stat     (fifo_stat)
	);

	msfp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.fifo_stat (fifo_stat),
		.rd_frame  (rd_frame),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_frame (out_frame)
	);

	assign speed_0 = out_frame[0];
	assign speed_1 = out_frame[1];
	assign speed_2 = out_frame[2];
	assign speed_3 = out_frame[3];
	assign speed_4 = out_frame[4];
	assign speed_5 = out_frame[5];

endmodule

@@ rtl/msfp_checker.sv @@
`timescale 1ns / 1ps

module msfp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        rx_valid,
	input logic        rx_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [15:0] speed_0
);

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(speed_0))
		else $error("stalled result dropped or changed");

	// A new result is always preceded by a taken byte
	a_out_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(rx_valid && !rx_stall, 2))
		else $error("result without a preceding checksum byte");

	// Input backpressure only while a result is held at the output
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		rx_stall |-> out_valid)
		else $error("input stalled with empty output");

	// Backpressure never starts without a valid output in the previous cycle
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rx_stall) |-> $past(out_valid))
		else $error("input stall rose without a pending result");

endmodule

bind motor_speed_frame_parser msfp_checker u_msfp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rx_valid  (rx_valid),
	.rx_stall  (rx_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.speed_0   (speed_0)
);

@@ sim/motor_speed_frame_parser_test.sv @@
`timescale 1ns / 1ps

module motor_speed_frame_parser_test;
	import msfp_pkg::*;

	// One row of the directed byte stream; typed rows carry a hand-written frame
	typedef struct {
		logic [7:0] data;
		bit         typed;
		frame_t     want;
	} byte_row_t;

	localparam int DIRECTED_ROWS = 19;
	localparam int PHASE_COUNT   = 8;
	localparam int PHASE_BYTES   = 130;
	localparam int HOLD_CYCLES   = 80;
	localparam int DRAIN_CYCLES  = 6;

	logic                 clk;
	logic                 arst_n;
	logic                 rx_valid;
	logic                 rx_stall;
	logic [7:0]           rx_byte;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [7:0]           cfg_data;
	logic                 out_valid;
	logic                 out_stall;
	logic [15:0]          speed_0;
	logic [15:0]          speed_1;
	logic [15:0]          speed_2;
	logic [15:0]          speed_3;
	logic [15:0]          speed_4;
	logic [15:0]          speed_5;

	// Parser mirror
	phase_t     pred_phase;
	int         pred_count;
	logic [7:0] pred_sum;
	logic [7:0] pred_payload [PAYLOAD_BYTES];
	logic [7:0] pred_sync_first;
	logic [7:0] pred_sync_second;

	frame_t     speed_frames_q [$];
	logic [7:0] frame_bytes [$];
	int         mismatches;
	int         burst_left;
	bit         no_gaps;
	bit         pressure_req;

	byte_row_t directed_rows [DIRECTED_ROWS] = '{
		'{8'hAA, 1'b0, '0},	// first sync
		'{8'hAA, 1'b0, '0},	// wrong second sync equal to first sync: not rechecked
		'{8'h55, 1'b0, '0},	// hunting again, ignored
		'{8'hAA, 1'b0, '0},
		'{8'h55, 1'b0, '0},
		'{8'hFF, 1'b0, '0},
		'{8'hFF, 1'b0, '0},
		'{8'h00, 1'b0, '0},
		'{8'h00, 1'b0, '0},
		'{8'h34, 1'b0, '0},
		'{8'h12, 1'b0, '0},
		'{8'hFF, 1'b0, '0},
		'{8'h00, 1'b0, '0},
		'{8'h00, 1'b0, '0},
		'{8'hFF, 1'b0, '0},
		'{8'h01, 1'b0, '0},
		'{8'h68, 1'b0, '0},
		// checksum equals first sync and matches: sum wraps to 0xAA
		'{8'hAA, 1'b1, {16'h6801, 16'hFF00, 16'h00FF, 16'h1234, 16'h0000, 16'hFFFF}},
		'{8'h55, 1'b0, '0}	// must not be taken as second sync
	};

	motor_speed_frame_parser u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx_valid  (rx_valid),
		.rx_stall  (rx_stall),
		.rx_byte   (rx_byte),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.speed_0   (speed_0),
		.speed_1   (speed_1),
		.speed_2   (speed_2),
		.speed_3   (speed_3),
		.speed_4   (speed_4),
		.speed_5   (speed_5)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("status: fail");
		$finish;
	end

	// Advance the parser mirror by one byte; return 1 when a frame with a matching checksum completes
	function automatic bit decode_byte(input logic [7:0] b, output frame_t fr);
		fr = '0;
		decode_byte = 1'b0;
		case (pred_phase)
			PH_HUNT: begin
				if (b == pred_sync_first) begin
					pred_phase = PH_SYNC2;
					pred_sum = b;
				end
			end
			PH_SYNC2: begin
				pred_count = 0;
				if (b == pred_sync_second) begin
					pred_phase = PH_PAYLOAD;
					pred_sum = pred_sum + b;
				end else begin
					pred_phase = PH_HUNT;
				end
			end
			PH_PAYLOAD: begin
				pred_payload[pred_count] = b;
				pred_sum = pred_sum + b;
				pred_count++;
				if (pred_count >= PAYLOAD_BYTES)
					pred_phase = PH_CHECK;
			end
			default: begin
				pred_phase = PH_HUNT;
				pred_count = 0;
				if (pred_sum == b) begin
					for (int k = 0; k < SPEED_COUNT; k++)
						fr[k] = {pred_payload[2 * k + 1], pred_payload[2 * k]};
					decode_byte = 1'b1;
				end
			end
		endcase
	endfunction

	// Offer one byte, wait for the transaction, then predict
	task automatic send_byte(input logic [7:0] b, input bit typed, input frame_t want);
		frame_t fr;
		if (!no_gaps && burst_left == 0) begin
			rx_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = $urandom_range(1, 40);
		end
		rx_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (rx_stall);
		if (burst_left > 0)
			burst_left--;
		if (decode_byte(b, fr))
			speed_frames_q.push_back(typed ? want : fr);
	endtask

	// Hold the sender until every frame is out and the pipeline is quiet
	task automatic wait_drained();
		rx_valid <= 1'b0;
		burst_left = 0;
		while (speed_frames_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_sync_bytes(input logic [7:0] first_v, input logic [7:0] second_v);
		cfg_we <= 1'b1;
		cfg_index <= REG_SYNC_FIRST;
		cfg_data <= first_v;
		@(posedge clk);
		pred_sync_first = first_v;
		cfg_index <= REG_SYNC_SECOND;
		cfg_data <= second_v;
		@(posedge clk);
		pred_sync_second = second_v;
		cfg_we <= 1'b0;
	endtask

	function automatic logic [7:0] payload_value();
		case ($urandom_range(0, 7))
			0: payload_value = 8'h00;
			1: payload_value = 8'hFF;
			default: payload_value = 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Queue a complete frame under the current sync bytes, optionally with a bad checksum
	task automatic build_frame(input bit corrupt);
		logic [7:0] sum;
		logic [7:0] b;
		sum = pred_sync_first + pred_sync_second;
		frame_bytes.push_back(pred_sync_first);
		frame_bytes.push_back(pred_sync_second);
		for (int i = 0; i < PAYLOAD_BYTES; i++) begin
			b = payload_value();
			sum = sum + b;
			frame_bytes.push_back(b);
		end
		if (corrupt)
			sum = sum ^ 8'($urandom_range(1, 255));
		frame_bytes.push_back(sum);
	endtask

	// Mostly clean frames, some broken ones and noise
	task automatic build_sequence();
		int pick;
		logic [7:0] b;
		pick = $urandom_range(0, 99);
		if (pick < 65) begin
			build_frame(1'b0);
		end else if (pick < 77) begin
			build_frame(1'b1);
		end else if (pick < 87) begin
			frame_bytes.push_back(pred_sync_first);
			do begin
				b = ($urandom_range(0, 1) == 1) ? pred_sync_first : 8'($urandom_range(0, 255));
			end while (b == pred_sync_second);
			frame_bytes.push_back(b);
		end else begin
			repeat ($urandom_range(1, 5)) begin
				b = ($urandom_range(0, 3) == 0) ? pred_sync_first : 8'($urandom_range(0, 255));
				frame_bytes.push_back(b);
			end
		end
	endtask

	// Receiver: check each output transaction, then pick the next stall
	initial begin
		frame_t got;
		frame_t want;
		int     hold_left;
		int     stall_mode;
		int     mode_left;
		int     tick;
		hold_left = 0;
		stall_mode = 0;
		mode_left = 0;
		tick = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				got = {speed_5, speed_4, speed_3, speed_2, speed_1, speed_0};
				if (speed_frames_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected speed frame %h", got);
				end else begin
					want = speed_frames_q.pop_front();
					for (int k = 0; k < SPEED_COUNT; k++) begin
						if (got[k] !== want[k]) begin
							mismatches++;
							if (mismatches <= 10)
								$display("speed_%0d mismatch: expected %h actual %h",
									k, want[k], got[k]);
						end
					end
				end
			end
			if (pressure_req) begin
				pressure_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (mode_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				mode_left = $urandom_range(20, 200);
			end
			mode_left--;
			tick++;
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				case (stall_mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 1) == 1);
					2: out_stall <= (tick % 4 == 0);
					default: out_stall <= ($urandom_range(0, 9) < 7);
				endcase
			end
		end
	end

	// Sender and run control
	initial begin
		logic [7:0] first_plan [PHASE_COUNT];
		logic [7:0] second_plan [PHASE_COUNT];
		int         sent;
		int         waited;
		first_plan = '{8'd170, 8'h00, 8'hFF, 8'h5A, 8'h00, 8'h00, 8'hFF, 8'h00};
		second_plan = '{8'd85, 8'hFF, 8'h00, 8'h5A, 8'h00, 8'h00, 8'hFF, 8'h00};
		first_plan[4] = 8'($urandom_range(0, 255));
		second_plan[4] = 8'($urandom_range(0, 255));
		first_plan[7] = 8'($urandom_range(0, 255));
		second_plan[7] = 8'($urandom_range(0, 255));

		mismatches = 0;
		burst_left = 0;
		no_gaps = 1'b0;
		pressure_req = 1'b0;
		pred_phase = PH_HUNT;
		pred_count = 0;
		pred_sum = '0;
		pred_sync_first = SYNC_FIRST_RST;
		pred_sync_second = SYNC_SECOND_RST;
		foreach (pred_payload[i])
			pred_payload[i] = '0;

		arst_n <= 1'b0;
		rx_valid <= 1'b0;
		rx_byte <= '0;
		cfg_we <= 1'b0;
		cfg_index <= REG_SYNC_FIRST;
		cfg_data <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed stream under reset sync values
		foreach (directed_rows[i])
			send_byte(directed_rows[i].data, directed_rows[i].typed, directed_rows[i].want);

		// Random phases, each under its own sync bytes; phases may end mid-frame
		for (int ph = 0; ph < PHASE_COUNT; ph++) begin
			wait_drained();
			set_sync_bytes(first_plan[ph], second_plan[ph]);
			sent = 0;
			while (sent < PHASE_BYTES) begin
				build_sequence();
				while (frame_bytes.size() != 0 && sent < PHASE_BYTES) begin
					send_byte(frame_bytes.pop_front(), 1'b0, '0);
					sent++;
				end
			end
			frame_bytes.delete();

			// Back-to-back frames against a long output hold to fill the queue
			if (ph == 3) begin
				wait_drained();
				pressure_req = 1'b1;
				no_gaps = 1'b1;
				repeat (8) build_frame(1'b0);
				while (frame_bytes.size() != 0)
					send_byte(frame_bytes.pop_front(), 1'b0, '0);
				no_gaps = 1'b0;
			end
		end

		// Drain and finish
		rx_valid <= 1'b0;
		waited = 0;
		while (speed_frames_q.size() != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (speed_frames_q.size() != 0) begin
			$display("%0d speed frames never arrived", speed_frames_q.size());
			mismatches += speed_frames_q.size();
		end
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
